// ----- design/qbz_pkg.sv -----
// ----------------------------------------------------------------------------
// qbz_pkg
// Shared constants and types of the quintic Bezier point evaluator.
// ----------------------------------------------------------------------------
package qbz_pkg;

	localparam int PARAM_BITS  = 16;
	localparam int COORD_BITS  = 32;
	localparam int NUM_PTS     = 6;
	localparam int DEG         = NUM_PTS - 1;
	localparam int T_W         = PARAM_BITS + 1;
	localparam int HALF_W      = 32;
	localparam int CFG_W       = 2 * HALF_W;
	localparam int CFG_IDX_W   = $clog2(NUM_PTS);
	localparam int OUT_W       = 32;
	localparam int SCALE_SHIFT = DEG * PARAM_BITS;
	localparam int VAL_MAX_W   = COORD_BITS + SCALE_SHIFT;
	localparam int CHUNK_W     = 32;
	localparam int PP_W        = CHUNK_W + PARAM_BITS + 3;
	localparam int STG_PER_LVL = 3;
	localparam int PIPE_DEPTH  = DEG * STG_PER_LVL + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [T_W-1:0]               tparam_t;

	localparam tparam_t T_ONE = tparam_t'(1) << PARAM_BITS;

endpackage

// ----- design/qbz_coord_pipe.sv -----
// ----------------------------------------------------------------------------
// qbz_coord_pipe
// One coordinate of the curve point: five de Casteljau levels in exact
// integer arithmetic, three register stages per level, then rounding.
// ----------------------------------------------------------------------------
module qbz_coord_pipe
	import qbz_pkg::*;
(
	input  logic    clk,
	input  tparam_t t_in,
	input  coord_t  ctrl [NUM_PTS],
	output coord_t  coord
);

	// Level k holds its values at scale 2^(k*PARAM_BITS), sign extended to full width.
	logic signed [VAL_MAX_W-1:0] lvl_val [DEG+1][NUM_PTS];
	tparam_t                     lvl_t   [DEG];

	for (genvar i = 0; i < NUM_PTS; i++) begin : g_in
		assign lvl_val[0][i] = VAL_MAX_W'(ctrl[i]);
	end
	assign lvl_t[0] = t_in;

	for (genvar k = 1; k <= DEG; k++) begin : g_lvl
		localparam int VIN_W  = COORD_BITS + PARAM_BITS * (k - 1);
		localparam int VOUT_W = VIN_W + PARAM_BITS;
		localparam int DIFF_W = VIN_W + 1;
		localparam int NCH    = (DIFF_W + CHUNK_W - 2) / CHUNK_W;
		localparam int LANES  = NUM_PTS - k;

		tparam_t t_s1;

		always_ff @(posedge clk) begin
			t_s1 <= lvl_t[k-1];
		end

		if (k < DEG) begin : g_tfwd
			tparam_t t_s2;
			tparam_t t_s3;
			always_ff @(posedge clk) begin
				t_s2 <= t_s1;
				t_s3 <= t_s2;
			end
			assign lvl_t[k] = t_s3;
		end

		for (genvar i = 0; i < NUM_PTS; i++) begin : g_lane
			if (i < LANES) begin : g_act
				logic signed [VIN_W-1:0]  base_s1;
				logic signed [VIN_W-1:0]  base_s2;
				logic signed [DIFF_W-1:0] diff_s1;
				logic signed [PP_W-1:0]   pp_d  [NCH];
				logic signed [PP_W-1:0]   pp_s2 [NCH];
				logic signed [VOUT_W-1:0] sum_d;
				logic signed [VOUT_W-1:0] val_s3;

				// s*a + t*b is rewritten as a*2^P + t*(b - a), one product per lane.
				always_ff @(posedge clk) begin
					base_s1 <= $signed(lvl_val[k-1][i][VIN_W-1:0]);
					diff_s1 <= $signed(lvl_val[k-1][i+1][DIFF_W-1:0])
						- $signed(lvl_val[k-1][i][DIFF_W-1:0]);
					base_s2 <= base_s1;
					pp_s2   <= pp_d;
					val_s3  <= sum_d;
				end

				// The difference is cut into 32-bit low slices and a top slice of up to 33 bits; only the top slice is signed.
				for (genvar j = 0; j < NCH; j++) begin : g_chunk
					localparam int LO = CHUNK_W * j;
					if (j == NCH - 1) begin : g_top
						assign pp_d[j] = PP_W'($signed(diff_s1[DIFF_W-1:LO])
							* $signed({1'b0, t_s1}));
					end else begin : g_low
						assign pp_d[j] = PP_W'($signed({1'b0, diff_s1[LO+CHUNK_W-1:LO]})
							* $signed({1'b0, t_s1}));
					end
				end

				// The true value fits in VOUT_W bits, so wrapping arithmetic is exact.
				always_comb begin
					sum_d = VOUT_W'(base_s2) << PARAM_BITS;
					for (int j = 0; j < NCH; j++) begin
						sum_d = sum_d + (VOUT_W'(pp_s2[j]) << (CHUNK_W * j));
					end
				end

				assign lvl_val[k][i] = VAL_MAX_W'(val_s3);
			end else begin : g_idle
				assign lvl_val[k][i] = '0;
			end
		end
	end

	// Round half up: add the bit just below the binary point.
	assign coord = lvl_val[DEG][0][VAL_MAX_W-1:SCALE_SHIFT]
		+ COORD_BITS'(lvl_val[DEG][0][SCALE_SHIFT-1]);

endmodule

// ----- design/quintic_bezier_point_eval.sv -----
// ----------------------------------------------------------------------------
// quintic_bezier_point_eval
// Evaluates a planar quintic Bezier curve at one parameter value per request.
// ----------------------------------------------------------------------------
// Usage:
// Control points are written through cfg_we / cfg_idx / cfg_wdata, one 64-bit
// register per point (x in bits 31:0, y in bits 63:32, signed Q16.16). Write
// them only while no request is in flight; indexes above five are ignored.
// A request is taken on each rising edge with start high and busy low. The
// parameter param_t is Q1.16 and values above 1.0 are treated as 1.0.
// Each result appears on point_x / point_y for one cycle with done high.
// A new request may be issued every cycle while busy is low, so the
// throughput is one point per clock. The pipeline is the parameter
// register, the five de Casteljau levels, each a difference, a multiply
// and an add stage, and then the output register.
// The receiver has no way to hold results off; done is a plain strobe.
// Reset clears the control points and all in-flight requests. busy is high
// during reset and until the first clock edge after it, and low from then on.
// ----------------------------------------------------------------------------
module quintic_bezier_point_eval
	import qbz_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [T_W-1:0]              param_t,
	output logic                        done,
	output logic signed [OUT_W-1:0]     point_x,
	output logic signed [OUT_W-1:0]     point_y,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_idx,
	input  logic [CFG_W-1:0]            cfg_wdata
);

	logic [CFG_W-1:0]        ctrl_point_q [NUM_PTS];
	logic                    busy_q;
	logic [PIPE_DEPTH-1:0]   vld_q;
	logic                    accept;
	tparam_t                 t_clamp;
	tparam_t                 t_s0;
	coord_t                  ctrl_x [NUM_PTS];
	coord_t                  ctrl_y [NUM_PTS];
	coord_t                  x_rnd;
	coord_t                  y_rnd;
	logic signed [OUT_W-1:0] point_x_q;
	logic signed [OUT_W-1:0] point_y_q;

	assign accept  = start && !busy_q;
	assign t_clamp = (param_t > T_ONE) ? T_ONE : param_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PTS; i++) begin
				ctrl_point_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_PTS))) begin
			ctrl_point_q[cfg_idx] <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_q  <= '0;
		end else begin
			busy_q <= 1'b0;
			vld_q  <= {vld_q[PIPE_DEPTH-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		t_s0      <= t_clamp;
		point_x_q <= OUT_W'(x_rnd);
		point_y_q <= OUT_W'(y_rnd);
	end

	for (genvar i = 0; i < NUM_PTS; i++) begin : g_split
		assign ctrl_x[i] = ctrl_point_q[i][COORD_BITS-1:0];
		assign ctrl_y[i] = ctrl_point_q[i][HALF_W+COORD_BITS-1:HALF_W];
	end

	qbz_coord_pipe u_pipe_x (
		.clk   (clk),
		.t_in  (t_s0),
		.ctrl  (ctrl_x),
		.coord (x_rnd)
	);

	qbz_coord_pipe u_pipe_y (
		.clk   (clk),
		.t_in  (t_s0),
		.ctrl  (ctrl_y),
		.coord (y_rnd)
	);

	assign busy    = busy_q;
	assign done    = vld_q[PIPE_DEPTH-1];
	assign point_x = point_x_q;
	assign point_y = point_y_q;

	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_DEPTH done)
		else $error("request did not produce a result at the expected latency");

	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_DEPTH))
		else $error("result strobe without a matching request");

	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose outside of reset");

	a_start_point: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(t_s0 == '0, PIPE_DEPTH - 1))
		|-> (point_x == OUT_W'($past(ctrl_x[0], PIPE_DEPTH - 1))))
		else $error("curve start does not match the first control point");

	a_end_point: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(t_s0 == T_ONE, PIPE_DEPTH - 1))
		|-> (point_y == OUT_W'($past(ctrl_y[DEG], PIPE_DEPTH - 1))))
		else $error("curve end does not match the last control point");

endmodule
